@@ design/integer_to_ascii_formatter_defines.svh @@
// Assertion macros used by the formatter back end (iaf_back).
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication.
`define IAF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/iaf_pkg.sv @@
`default_nettype none

package iaf_pkg;

   localparam int MAX_FIELD   = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int MAG_W       = 64;
   localparam int FIELD_W     = 7;

   typedef enum logic [1:0] {
      BASE_BIN = 2'd0,
      BASE_OCT = 2'd1,
      BASE_DEC = 2'd2,
      BASE_HEX = 2'd3
   } base_type;

   typedef enum logic [1:0] {
      PAD_SPACE = 2'd0,
      PAD_ZERO  = 2'd1,
      PAD_LEFT  = 2'd2
   } pad_mode_type;

   // classified number, as queued between front and back
   typedef struct packed {
      logic [MAG_W-1:0]   magnitude;
      base_type           base;
      logic               negative;
      logic [FIELD_W-1:0] width;      // already clamped to the max field
      pad_mode_type       pad_mode;
      logic               upper_case;
   } cmd_type;

endpackage

`default_nettype wire

@@ design/iaf_front.sv @@
`default_nettype none

module iaf_front #(
   parameter int MaxField = iaf_pkg::MAX_FIELD
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [iaf_pkg::MAG_W-1:0]     req_magnitude,
   input  logic [1:0]                    req_base_select,
   input  logic                          req_negative,
   input  logic [iaf_pkg::FIELD_W-1:0]   req_field_width,
   input  logic                          req_left_adjust,
   input  logic                          req_zero_pad,
   input  logic                          req_upper_case,
   output logic                          cmd_valid,
   output iaf_pkg::cmd_type              cmd,
   input  logic                          cmd_ready
);

   localparam int Depth  = iaf_pkg::QUEUE_DEPTH;
   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   iaf_pkg::cmd_type  entry_ff [Depth];
   iaf_pkg::cmd_type  entry_in;
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              push_fire, pop_fire;

   // classify: clamp width, fold the flags into one pad mode
   always_comb begin
      entry_in.magnitude  = req_magnitude;
      entry_in.base       = iaf_pkg::base_type'(req_base_select);
      entry_in.negative   = req_negative;
      entry_in.upper_case = req_upper_case;
      if (req_field_width > iaf_pkg::FIELD_W'(MaxField)) begin
         entry_in.width = iaf_pkg::FIELD_W'(MaxField);
      end else begin
         entry_in.width = req_field_width;
      end
      priority if (req_left_adjust) begin
         entry_in.pad_mode = iaf_pkg::PAD_LEFT;
      end else if (req_zero_pad) begin
         entry_in.pad_mode = iaf_pkg::PAD_ZERO;
      end else begin
         entry_in.pad_mode = iaf_pkg::PAD_SPACE;
      end
   end

   assign req_full  = (count_ff == CountW'(Depth));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign push_fire = req_push && !req_full;
   assign pop_fire  = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CountW'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

@@ design/iaf_back.sv @@
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"

module iaf_back #(
   parameter int MaxField = iaf_pkg::MAX_FIELD
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  iaf_pkg::cmd_type cmd,
   output logic             cmd_ready,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [7:0]       rsp_character,
   output logic             rsp_last_char
);

   localparam int DwordW  = 80;              // 20 BCD digits
   localparam int NibbleN = DwordW / 4;
   localparam int CntW    = iaf_pkg::FIELD_W;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] DIGIT_TEN    = 8'd10;
   localparam logic [3:0] DEC_MAX      = 4'd9;
   localparam logic [3:0] BCD_LIMIT    = 4'd5;
   localparam logic [3:0] BCD_ADJUST   = 4'd3;

   localparam logic [CntW-1:0] DIGITS_BIN = CntW'(64);
   localparam logic [CntW-1:0] DIGITS_OCT = CntW'(22);
   localparam logic [CntW-1:0] DIGITS_DEC = CntW'(20);
   localparam logic [CntW-1:0] DIGITS_HEX = CntW'(16);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CONV  = 9'b000000010,
      ST_SCAN  = 9'b000000100,
      ST_TRIM  = 9'b000001000,
      ST_PRE   = 9'b000010000,
      ST_SIGN  = 9'b000100000,
      ST_ZERO  = 9'b001000000,
      ST_DIGIT = 9'b010000000,
      ST_POST  = 9'b100000000
   } state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] letter_base;
      letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d <= DEC_MAX) begin
         return CHAR_ZERO + {4'b0, d};
      end
      return letter_base + {4'b0, d} - DIGIT_TEN;
   endfunction

   function automatic logic [CntW-1:0] max_digits(input iaf_pkg::base_type b);
      logic [CntW-1:0] n;
      unique case (b)
         iaf_pkg::BASE_BIN: n = DIGITS_BIN;
         iaf_pkg::BASE_OCT: n = DIGITS_OCT;
         iaf_pkg::BASE_DEC: n = DIGITS_DEC;
         iaf_pkg::BASE_HEX: n = DIGITS_HEX;
         default:           n = DIGITS_HEX;
      endcase
      return n;
   endfunction

   state_type             state_ff, state_in;
   iaf_pkg::base_type     base_ff, base_in;
   iaf_pkg::pad_mode_type mode_ff, mode_in;
   logic                  neg_ff, neg_in;
   logic                  upper_ff, upper_in;
   logic [CntW-1:0]       width_ff, width_in;
   logic [iaf_pkg::MAG_W-1:0] mag_ff, mag_in;
   logic [DwordW-1:0]     dword_ff, dword_in;
   logic [5:0]            step_ff, step_in;
   logic [CntW-1:0]       nd_ff, nd_in;
   logic [CntW-1:0]       pad_ff, pad_in;
   logic [CntW-1:0]       rem_ff, rem_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;

   logic [3:0]        top_digit;
   logic [DwordW-1:0] dword_shift;
   logic [DwordW-1:0] bcd_adj;
   logic [CntW-1:0]   content;
   logic [CntW-1:0]   pad_calc;
   logic              emitting, emit_fire;
   logic [7:0]        emit_char;

   // digits sit left aligned: most significant digit at a fixed slice per base
   always_comb begin
      unique case (base_ff)
         iaf_pkg::BASE_BIN: begin
            top_digit   = {3'b0, dword_ff[63]};
            dword_shift = {dword_ff[DwordW-2:0], 1'b0};
         end
         iaf_pkg::BASE_OCT: begin
            top_digit   = {1'b0, dword_ff[65:63]};
            dword_shift = {dword_ff[DwordW-4:0], 3'b0};
         end
         iaf_pkg::BASE_DEC: begin
            top_digit   = dword_ff[79:76];
            dword_shift = {dword_ff[DwordW-5:0], 4'b0};
         end
         default: begin
            top_digit   = dword_ff[63:60];
            dword_shift = {dword_ff[DwordW-5:0], 4'b0};
         end
      endcase
   end

   // double-dabble add-3 on every BCD digit
   always_comb begin
      for (int i = 0; i < NibbleN; i++) begin
         bcd_adj[4*i +: 4] = (dword_ff[4*i +: 4] >= BCD_LIMIT) ?
                             dword_ff[4*i +: 4] + BCD_ADJUST : dword_ff[4*i +: 4];
      end
   end

   assign content  = nd_ff + CntW'(neg_ff);
   assign pad_calc = (width_ff > content) ? width_ff - content : '0;

   assign emitting  = (state_ff == ST_PRE) || (state_ff == ST_SIGN) ||
                      (state_ff == ST_ZERO) || (state_ff == ST_DIGIT) ||
                      (state_ff == ST_POST);
   assign emit_fire = emitting && (!out_valid_ff || rsp_pop);
   assign cmd_ready = (state_ff == ST_IDLE);

   always_comb begin
      unique case (state_ff)
         ST_SIGN:  emit_char = CHAR_MINUS;
         ST_ZERO:  emit_char = CHAR_ZERO;
         ST_DIGIT: emit_char = digit_char(top_digit, upper_ff);
         default:  emit_char = CHAR_SPACE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      mode_in  = mode_ff;
      neg_in   = neg_ff;
      upper_in = upper_ff;
      width_in = width_ff;
      mag_in   = mag_ff;
      dword_in = dword_ff;
      step_in  = step_ff;
      nd_in    = nd_ff;
      pad_in   = pad_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               base_in  = cmd.base;
               mode_in  = cmd.pad_mode;
               neg_in   = cmd.negative;
               upper_in = cmd.upper_case;
               width_in = cmd.width;
               mag_in   = cmd.magnitude;
               step_in  = '0;
               if (cmd.base == iaf_pkg::BASE_DEC) begin
                  dword_in = '0;
                  state_in = ST_CONV;
               end else begin
                  dword_in = {(DwordW - iaf_pkg::MAG_W)'(0), cmd.magnitude};
                  nd_in    = max_digits(cmd.base);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CONV: begin
            dword_in = {bcd_adj[DwordW-2:0], mag_ff[iaf_pkg::MAG_W-1]};
            mag_in   = {mag_ff[iaf_pkg::MAG_W-2:0], 1'b0};
            step_in  = step_ff + 6'd1;
            if (step_ff == '1) begin
               nd_in    = DIGITS_DEC;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (top_digit == '0 && nd_ff > CntW'(1)) begin
               dword_in = dword_shift;
               nd_in    = nd_ff - CntW'(1);
            end else begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // drop leading characters, sign first, past the max field
            if (content > CntW'(MaxField)) begin
               if (neg_ff) begin
                  neg_in = 1'b0;
               end else begin
                  dword_in = dword_shift;
                  nd_in    = nd_ff - CntW'(1);
               end
            end else begin
               pad_in = pad_calc;
               rem_in = content + pad_calc;
               unique case (mode_ff)
                  iaf_pkg::PAD_LEFT: state_in = neg_ff ? ST_SIGN : ST_DIGIT;
                  iaf_pkg::PAD_ZERO: begin
                     if (neg_ff) begin
                        state_in = ST_SIGN;
                     end else begin
                        state_in = (pad_calc != '0) ? ST_ZERO : ST_DIGIT;
                     end
                  end
                  default: begin
                     if (pad_calc != '0) begin
                        state_in = ST_PRE;
                     end else begin
                        state_in = neg_ff ? ST_SIGN : ST_DIGIT;
                     end
                  end
               endcase
            end
         end
         ST_PRE: begin
            if (emit_fire) begin
               pad_in = pad_ff - CntW'(1);
               if (pad_ff == CntW'(1)) begin
                  state_in = neg_ff ? ST_SIGN : ST_DIGIT;
               end
            end
         end
         ST_SIGN: begin
            if (emit_fire) begin
               state_in = (mode_ff == iaf_pkg::PAD_ZERO && pad_ff != '0) ?
                          ST_ZERO : ST_DIGIT;
            end
         end
         ST_ZERO: begin
            if (emit_fire) begin
               pad_in = pad_ff - CntW'(1);
               if (pad_ff == CntW'(1)) begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_DIGIT: begin
            if (emit_fire) begin
               dword_in = dword_shift;
               nd_in    = nd_ff - CntW'(1);
               if (nd_ff == CntW'(1)) begin
                  state_in = ST_POST;
               end
            end
         end
         ST_POST: begin
            if (emit_fire) begin
               pad_in = pad_ff - CntW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (emit_fire) begin
         rem_in = rem_ff - CntW'(1);
         if (rem_ff == CntW'(1)) begin
            state_in = ST_IDLE;
         end
      end
   end

   // one-entry result register
   always_comb begin
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      if (emit_fire) begin
         out_valid_in = 1'b1;
         out_char_in  = emit_char;
         out_last_in  = (rem_ff == CntW'(1));
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_last_char = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      mode_ff     <= mode_in;
      neg_ff      <= neg_in;
      upper_ff    <= upper_in;
      width_ff    <= width_in;
      mag_ff      <= mag_in;
      dword_ff    <= dword_in;
      step_ff     <= step_in;
      nd_ff       <= nd_in;
      pad_ff      <= pad_in;
      rem_ff      <= rem_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   `IAF_ASSERT_SAME(a_digits_left, clock, reset,
      (state_ff == ST_SCAN || state_ff == ST_TRIM || state_ff == ST_DIGIT),
      (nd_ff != '0), "digit count ran out while digits still pending")
   `IAF_ASSERT_SAME(a_rem_range, clock, reset, emitting,
      (rem_ff != '0) && (rem_ff <= CntW'(MaxField)), "remaining count out of range")
   `IAF_ASSERT_SAME(a_rem_covers_digits, clock, reset, (state_ff == ST_DIGIT),
      (rem_ff >= nd_ff), "fewer characters left than digits")
   `IAF_ASSERT_NEXT(a_last_to_idle, clock, reset, emit_fire && (rem_ff == CntW'(1)),
      (state_ff == ST_IDLE) && out_valid_ff && out_last_ff, "last character not closed")

endmodule

`default_nettype wire

@@ design/integer_to_ascii_formatter.sv @@
// Channel   | Ports                                 | Transfer when
// ----------+---------------------------------------+--------------------
// request   | req_push, req_full, req_<fields>      | req_push && !req_full
// response  | rsp_pop, rsp_empty, rsp_character,    | rsp_pop && !rsp_empty
//           | rsp_last_char                         |
//
// Per number: decimal first runs shift-add-3 BCD conversion of all 64 bits;
// every base then scans off leading zero digits (one digit per cycle, up to
// the base's digit count, 20 for decimal), trims and emits the characters.
// Trim drops leading characters, sign first, past the max field.
// Characters leave at one per cycle while rsp_pop stays high.
// Reset is synchronous, active high; it empties the queue and the result reg.
// A two-entry request queue lets new numbers arrive while one is formatted.
`default_nettype none

module integer_to_ascii_formatter #(
   parameter int MaxField = iaf_pkg::MAX_FIELD
) (
   input  logic                        clock,
   input  logic                        reset,
   // request side
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [iaf_pkg::MAG_W-1:0]   req_magnitude,
   input  logic [1:0]                  req_base_select,
   input  logic                        req_negative,
   input  logic [iaf_pkg::FIELD_W-1:0] req_field_width,
   input  logic                        req_left_adjust,
   input  logic                        req_zero_pad,
   input  logic                        req_upper_case,
   // response side
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic [7:0]                  rsp_character,
   output logic                        rsp_last_char
);

   // front -> back command transfer
   logic             cmd_valid;
   logic             cmd_ready;
   iaf_pkg::cmd_type cmd;

   // front: clamps width, resolves pad mode, queues the number
   iaf_front #(
      .MaxField(MaxField)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_magnitude  (req_magnitude),
      .req_base_select(req_base_select),
      .req_negative   (req_negative),
      .req_field_width(req_field_width),
      .req_left_adjust(req_left_adjust),
      .req_zero_pad   (req_zero_pad),
      .req_upper_case (req_upper_case),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_ready      (cmd_ready)
   );

   // back: digit extraction, field layout, per-character output register
   iaf_back #(
      .MaxField(MaxField)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_ready    (cmd_ready),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_character(rsp_character),
      .rsp_last_char(rsp_last_char)
   );

endmodule

`default_nettype wire
